>>> hw/rtl/glrd_pkg.sv
package glrd_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_BACKUP_EN  = 2'd0,
    REG_SKIP_OLD   = 2'd1,
    REG_START_TIME = 2'd2
  } cfg_reg_t;

  localparam logic [31:0] ERASED_WORD = 32'hFFFF_FFFF;
  localparam logic [31:0] SIGN_ADD    = 32'h8000_0000;
  localparam int          FRAC_BITS   = 24;

  // Reciprocals for the constant divisions
  // w / 1000000 = (w >> 6) / 15625 = (x * M_DEG) >> 40, exact for x < 2**26
  localparam logic [26:0] M_DEG     = 27'd70368745;
  localparam logic [19:0] DIGIT_SPLIT = 20'd1000000;
  // (mins << 24) / 600000 = (mins << 18) / 9375; estimate is low by at most 1
  localparam logic [28:0] M_MIN     = 29'd469124961;
  localparam logic [13:0] MIN_DIV   = 14'd9375;
  // y / 125 = (y * M_SPD) >> 31, exact for y < 2**24
  localparam logic [24:0] M_SPD     = 25'd17179870;

  // One record as it travels from the front to the back
  typedef struct packed {
    logic [31:0] longitude_raw;
    logic [31:0] latitude_raw;
    logic [31:0] time_raw;
    logic [15:0] altitude_raw;
    logic [7:0]  speed_knots;
    logic        append;
  } glrd_item_t;

  // Fields that ride alongside the coordinate lanes
  typedef struct packed {
    logic [31:0] epoch;
    logic        ok;
    logic [17:0] speed;
    logic [15:0] altitude;
    logic        append;
  } glrd_side_t;

  // Day of year at the first of each month, non-leap
  function automatic logic [8:0] month_start(input logic [3:0] mon);
    logic [8:0] d;
    unique case (mon)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

>>> hw/rtl/gps_log_record_decoder.sv
// Channel  Handshake               Payload
// cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
// in       in_valid / in_stall     longitude_raw .. speed_knots
// out      out_valid / out_stall   longitude_deg .. append_to_backup
//
// One record per cycle sustained while out_stall is low; a record is written
// to the queue at the transfer edge, then passes the 8-stage decode pipeline,
// whose first stage loads as the queue is read.
// The erased check and kept-time compare finish in the transfer cycle.
// rst is synchronous and clears config, kept time, queue and stage valids.
// out_stall with out_valid high freezes the decode pipeline; the queue absorbs
// records until it fills, then in_stall rises. cfg_ready is always high.
module gps_log_record_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [31:0]         longitude_raw,
  input  logic [31:0]         latitude_raw,
  input  logic [31:0]         time_raw,
  input  logic [15:0]         altitude_raw,
  input  logic [7:0]          speed_knots,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [36:0]  longitude_deg,
  output logic signed [36:0]  latitude_deg,
  output logic [31:0]         epoch_seconds,
  output logic                date_ok,
  output logic [17:0]         speed_mm_s,
  output logic [15:0]         altitude_m,
  output logic                append_to_backup
);
  import glrd_pkg::*;

  logic       push;
  glrd_item_t push_item;
  logic       q_full;
  logic       head_valid;
  glrd_item_t head_item;
  logic       pop;

  glrd_front u_front (
    .clk, .rst,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_stall,
    .longitude_raw, .latitude_raw, .time_raw, .altitude_raw, .speed_knots,
    .q_full, .push, .push_item
  );

  glrd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst,
    .push, .push_item,
    .full(q_full),
    .head_valid, .head_item, .pop
  );

  glrd_back u_back (
    .clk, .rst,
    .head_valid, .head_item, .pop,
    .out_valid, .out_stall,
    .longitude_deg, .latitude_deg, .epoch_seconds, .date_ok,
    .speed_mm_s, .altitude_m, .append_to_backup
  );

endmodule

>>> hw/rtl/glrd_front.sv
module glrd_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [31:0]          longitude_raw,
  input  logic [31:0]          latitude_raw,
  input  logic [31:0]          time_raw,
  input  logic [15:0]          altitude_raw,
  input  logic [7:0]           speed_knots,
  input  logic                 q_full,
  output logic                 push,
  output glrd_pkg::glrd_item_t push_item
);
  import glrd_pkg::*;

  logic        backup_en;
  logic        skip_old;
  logic [31:0] kept_time;
  logic        accept;
  logic        erased;
  logic        newer;
  logic        cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign in_stall  = q_full;
  assign accept    = in_valid && !in_stall;
  assign erased    = (longitude_raw == ERASED_WORD);
  assign newer     = (time_raw > kept_time);

  // Classify: drop erased slots and, with backup and skip-old set, records not newer
  assign push = accept && !erased && !(backup_en && skip_old && !newer);

  always_comb begin
    push_item.longitude_raw = longitude_raw;
    push_item.latitude_raw  = latitude_raw;
    push_item.time_raw      = time_raw;
    push_item.altitude_raw  = altitude_raw;
    push_item.speed_knots   = speed_knots;
    push_item.append        = backup_en && newer;
  end

  // Configuration registers and kept time
  always_ff @(posedge clk) begin
    if (rst) begin
      backup_en <= 1'b0;
      skip_old  <= 1'b0;
      kept_time <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_BACKUP_EN:  backup_en <= cfg_data[0];
          REG_SKIP_OLD:   skip_old  <= cfg_data[0];
          REG_START_TIME: kept_time <= cfg_data;
          default: ;
        endcase
      end else if (accept && !erased && backup_en && newer) begin
        kept_time <= time_raw;
      end
    end
  end

`ifndef SYNTHESIS
  // Kept time only moves forward unless reloaded
  assert property (@(posedge clk) disable iff (rst)
    !(cfg_we && cfg_index == REG_START_TIME) |=> kept_time >= $past(kept_time))
    else $error("kept time went backwards");
`endif

endmodule

>>> hw/rtl/glrd_queue.sv
module glrd_queue #(
  parameter int DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  glrd_pkg::glrd_item_t push_item,
  output logic                 full,
  output logic                 head_valid,
  output glrd_pkg::glrd_item_t head_item,
  input  logic                 pop
);
  import glrd_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  glrd_item_t    entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_pop;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = entries[rd_ptr];
  assign do_pop     = pop && head_valid;

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");
  assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("queue count overflow");
`endif

endmodule

>>> hw/rtl/glrd_back.sv
module glrd_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 head_valid,
  input  glrd_pkg::glrd_item_t head_item,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [36:0]   longitude_deg,
  output logic signed [36:0]   latitude_deg,
  output logic [31:0]          epoch_seconds,
  output logic                 date_ok,
  output logic [17:0]          speed_mm_s,
  output logic [15:0]          altitude_m,
  output logic                 append_to_backup
);
  import glrd_pkg::*;

  // Stage valids, s1..s8; s8 is the output register
  logic [8:1] v;
  logic       en;

  // Coordinate lanes: 0 longitude, 1 latitude
  logic        neg    [1:7][2];
  logic [31:0] w      [2:4][2];
  logic [52:0] prod2  [2];
  logic [12:0] deg    [3:7][2];
  logic [32:0] degm3  [2];
  logic [19:0] mins   [4:6][2];
  logic [48:0] p5     [2];
  logic [24:0] qe6    [2];
  logic [38:0] t6     [2];
  logic [24:0] q7     [2];
  logic [36:0] res8   [2];

  // Side fields
  logic [16:0] dcount1;
  logic [16:0] sod1;
  logic        ok1;
  logic [26:0] x1;
  logic [15:0] alt1;
  logic        app1;
  logic [31:0] epoch2;
  logic        ok2;
  logic [48:0] sprod2;
  logic [15:0] alt2;
  logic        app2;
  glrd_side_t  side   [3:8];

  // Time fields of the queue head
  logic [5:0]  t_sec;
  logic [5:0]  t_min;
  logic [4:0]  t_hr;
  logic [4:0]  t_day;
  logic [3:0]  t_mon;
  logic [5:0]  t_yr;
  logic [16:0] yr_off;
  logic [16:0] leap;
  logic [6:0]  leap_cnt;
  logic [33:0] total;
  logic [37:0] rem7   [2];
  logic [36:0] mag8   [2];
  logic [31:0] coord_in [2];

  assign en  = !(v[8] && out_stall);
  assign pop = en && head_valid;

  assign t_sec    = head_item.time_raw[5:0];
  assign t_min    = head_item.time_raw[11:6];
  assign t_hr     = head_item.time_raw[16:12];
  assign t_day    = head_item.time_raw[21:17];
  assign t_mon    = head_item.time_raw[25:22];
  assign t_yr     = head_item.time_raw[31:26];
  assign yr_off   = 17'(t_yr) + 17'd30;
  assign leap_cnt = (7'(t_yr) + 7'd31) >> 2;
  assign leap     = (t_yr[1:0] == 2'b00 && t_mon > 4'd2) ? 17'd1 : 17'd0;
  assign total    = 34'(dcount1) * 34'd86400 + 34'(sod1);

  assign coord_in[0] = head_item.longitude_raw;
  assign coord_in[1] = head_item.latitude_raw;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      rem7[i] = {mins[6][i], 18'b0} - t6[i][37:0];
      mag8[i] = {deg[7][i], 24'b0} + 37'(q7[i]);
    end
  end

  // Valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[7:1], head_valid};
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 2; i++) begin
        // s1: strip sign word
        neg[1][i] <= (coord_in[i] > SIGN_ADD);
        w[2][i]   <= (coord_in[i] > SIGN_ADD) ? coord_in[i] - SIGN_ADD : coord_in[i];
        // s2: degree reciprocal product
        prod2[i]  <= 53'(w[2][i][31:6]) * 53'(M_DEG);
        w[3][i]   <= w[2][i];
        // s3: degrees and their digit weight
        deg[3][i] <= prod2[i][52:40];
        degm3[i]  <= 33'(prod2[i][52:40]) * 33'(DIGIT_SPLIT);
        w[4][i]   <= w[3][i];
        // s4: minute digits
        deg[4][i]  <= deg[3][i];
        mins[4][i] <= 20'(w[4][i] - degm3[i][31:0]);
        // s5: fraction reciprocal product
        deg[5][i]  <= deg[4][i];
        mins[5][i] <= mins[4][i];
        p5[i]      <= 49'(mins[4][i]) * 49'(M_MIN);
        // s6: estimate and back-multiply
        deg[6][i]  <= deg[5][i];
        mins[6][i] <= mins[5][i];
        qe6[i]     <= p5[i][48:24];
        t6[i]      <= 39'(p5[i][48:24]) * 39'(MIN_DIV);
        // s7: correct estimate
        deg[7][i]  <= deg[6][i];
        q7[i]      <= qe6[i] + ((rem7[i] >= 38'(MIN_DIV)) ? 25'd1 : 25'd0);
        // s8: apply sign
        res8[i]    <= neg[7][i] ? 37'd0 - mag8[i] : mag8[i];
      end
      for (int s = 2; s < 8; s++) begin
        neg[s] <= neg[s-1];
      end

      // s1: day count, second of day, speed product
      dcount1 <= yr_off * 17'd365 + 17'(leap_cnt) + 17'(month_start(t_mon)) + leap
                 + 17'(t_day) - 17'd1;
      sod1    <= 17'(t_hr) * 17'd3600 + 17'(t_min) * 17'd60 + 17'(t_sec);
      ok1     <= (t_mon >= 4'd1) && (t_mon <= 4'd12);
      x1      <= 27'(head_item.speed_knots) * 27'd514444 + 27'd500;
      alt1    <= head_item.altitude_raw;
      app1    <= head_item.append;
      // s2: epoch and speed reciprocal
      epoch2  <= ok1 ? total[31:0] : 32'd0;
      ok2     <= ok1;
      sprod2  <= 49'(x1[26:3]) * 49'(M_SPD);
      alt2    <= alt1;
      app2    <= app1;
      // s3: gather side fields, then ride along
      side[3].epoch    <= epoch2;
      side[3].ok       <= ok2;
      side[3].speed    <= sprod2[48:31];
      side[3].altitude <= alt2;
      side[3].append   <= app2;
      for (int s = 4; s <= 8; s++) begin
        side[s] <= side[s-1];
      end
    end
  end

  assign out_valid        = v[8];
  assign longitude_deg    = res8[0];
  assign latitude_deg     = res8[1];
  assign epoch_seconds    = side[8].epoch;
  assign date_ok          = side[8].ok;
  assign speed_mm_s       = side[8].speed;
  assign altitude_m       = side[8].altitude;
  assign append_to_backup = side[8].append;

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !date_ok |-> epoch_seconds == 32'd0)
    else $error("bad date with nonzero epoch");
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> speed_mm_s <= 18'd131183)
    else $error("speed out of range");
`endif

endmodule

>>> bench/gps_log_record_decoder_tb.sv
module gps_log_record_decoder_tb;
  import glrd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] lon;
    logic [31:0] lat;
    logic [31:0] tim;
    logic [15:0] alt;
    logic [7:0]  spd;
  } record_t;

  typedef struct {
    logic signed [36:0] lon_deg;
    logic signed [36:0] lat_deg;
    logic [31:0] epoch;
    logic        ok;
    logic [17:0] speed;
    logic [15:0] alt;
    logic        append;
  } fix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [31:0] longitude_raw = '0, latitude_raw = '0, time_raw = '0;
  logic [15:0] altitude_raw = '0;
  logic [7:0] speed_knots = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [36:0] longitude_deg, latitude_deg;
  logic [31:0] epoch_seconds;
  logic date_ok;
  logic [17:0] speed_mm_s;
  logic [15:0] altitude_m;
  logic append_to_backup;

  gps_log_record_decoder uut (.*);

  always #6 clk = ~clk;

  // predictor state
  logic        bk_en, skip_old_q;
  logic [31:0] kept_time;
  record_t     pending_records[$];
  fix_t        expected_fixes[$];
  int          mismatches = 0;
  bit          quiet = 1'b0;
  bit          driver_busy = 1'b0;
  bit          in_acc = 1'b0;

  function automatic logic [36:0] coord_fixed(input logic [31:0] w);
    bit neg;
    logic [63:0] deg, mins, mag;
    neg = w > SIGN_ADD;
    if (neg) w = w - SIGN_ADD;
    deg = w / 1000000;
    mins = w - deg * 1000000;
    mag = (deg << 24) + ((mins << 24) / 600000);
    if (neg) mag = 64'd0 - mag;
    return mag[36:0];
  endfunction

  function automatic logic [31:0] epoch_of(input logic [31:0] t, output logic ok);
    int unsigned mstart[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
    logic [63:0] days, total;
    int unsigned mon, year;
    mon = t[25:22];
    year = t[31:26] + 2000;
    ok = (mon >= 1 && mon <= 12);
    if (!ok) return 32'd0;
    days = 64'(year - 1970) * 365 + (year - 1969) / 4 + mstart[mon - 1];
    if (year % 4 == 0 && mon > 2) days++;
    total = days * 86400 + 64'(t[16:12]) * 3600 + 64'(t[11:6]) * 60 + t[5:0]
            + 64'(t[21:17]) * 86400 - 86400;
    return total[31:0];
  endfunction

  // work out the fix produced by one accepted record, if any
  task automatic predict_fix(input record_t r);
    fix_t f;
    f.append = 1'b0;
    if (r.lon == ERASED_WORD) return;
    if (bk_en) begin
      if (r.tim > kept_time) begin
        kept_time = r.tim;
        f.append = 1'b1;
      end else if (skip_old_q) begin
        return;
      end
    end
    f.lon_deg = coord_fixed(r.lon);
    f.lat_deg = coord_fixed(r.lat);
    f.epoch = epoch_of(r.tim, f.ok);
    f.speed = 18'((32'(r.spd) * 514444 + 500) / 1000);
    f.alt = r.alt;
    expected_fixes.push_back(f);
  endtask

  // driver: one record per transfer, random bursts of idle
  int in_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || in_acc) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_records.size() > 0) begin
          record_t r;
          r = pending_records.pop_front();
          longitude_raw <= r.lon;
          latitude_raw <= r.lat;
          time_raw <= r.tim;
          altitude_raw <= r.alt;
          speed_knots <= r.spd;
          in_valid <= 1'b1;
          if (!quiet && $urandom_range(0, 5) == 0) in_gap <= $urandom_range(1, 9);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // sample transfers at the rising edge
  always @(posedge clk) begin
    in_acc <= in_valid && !in_stall && !rst;
    if (!rst && in_valid && !in_stall)
      predict_fix('{longitude_raw, latitude_raw, time_raw, altitude_raw, speed_knots});
  end

  always @(posedge clk) driver_busy <= in_valid || pending_records.size() > 0;

  // receiver stall bursts
  int out_gap = 0;
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 6) == 0) begin
      out_gap <= $urandom_range(0, 8);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor: compare each output transfer with the oldest expected fix
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_fixes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output transfer at %0t", $realtime);
      end else begin
        fix_t e;
        e = expected_fixes.pop_front();
        if (longitude_deg !== e.lon_deg || latitude_deg !== e.lat_deg ||
            epoch_seconds !== e.epoch || date_ok !== e.ok ||
            speed_mm_s !== e.speed || altitude_m !== e.alt ||
            append_to_backup !== e.append) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp lon %0d lat %0d ep %0d ok %b spd %0d alt %0d app %b",
                     e.lon_deg, e.lat_deg, e.epoch, e.ok, e.speed, e.alt, e.append,
                     "\n          got lon %0d lat %0d ep %0d ok %b spd %0d alt %0d app %b",
                     longitude_deg, latitude_deg, epoch_seconds, date_ok, speed_mm_s,
                     altitude_m, append_to_backup);
        end
      end
    end
  end

  // register write, block idle
  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_BACKUP_EN:  bk_en = data[0];
      REG_SKIP_OLD:   skip_old_q = data[0];
      REG_START_TIME: kept_time = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain;
    while (pending_records.size() > 0 || driver_busy || in_valid ||
           expected_fixes.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord;
    logic [31:0] w;
    case ($urandom_range(0, 5))
      0: w = $urandom;
      1: w = SIGN_ADD + $urandom_range(0, 180) * 1000000 + $urandom_range(0, 599999);
      2: w = SIGN_ADD;
      default: w = $urandom_range(0, 180) * 1000000 + $urandom_range(0, 999999);
    endcase
    return w;
  endfunction

  function automatic logic [31:0] rand_time;
    logic [31:0] t;
    t = $urandom;
    if ($urandom_range(0, 4) != 0) t[25:22] = $urandom_range(1, 12);
    return t;
  endfunction

  task automatic add_random(input int n, input logic [31:0] base);
    record_t r;
    logic [31:0] t;
    t = base;
    repeat (n) begin
      r.lon = ($urandom_range(0, 19) == 0) ? ERASED_WORD : rand_coord();
      r.lat = rand_coord();
      // mostly rising times so records stay new, some going back
      if ($urandom_range(0, 3) == 0) t = rand_time();
      else t = t + $urandom_range(0, 5000);
      r.tim = t;
      r.alt = $urandom;
      r.spd = $urandom;
      pending_records.push_back(r);
    end
  endtask

  initial begin
    bk_en = 1'b0;
    skip_old_q = 1'b0;
    kept_time = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: field extremes and special cases, backup off
    pending_records.push_back('{32'h0, 32'h0, 32'h0, 16'h0, 8'h0});
    pending_records.push_back('{32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF});
    pending_records.push_back('{ERASED_WORD, 32'h1234, 32'h0440_0000, 16'd5, 8'd1});
    pending_records.push_back('{SIGN_ADD, SIGN_ADD + 1, {6'd24, 4'd2, 5'd29, 5'd12, 6'd0, 6'd0},
                                16'd100, 8'd2});
    pending_records.push_back('{32'd179_999999, SIGN_ADD + 32'd90_000000,
                                {6'd0, 4'd1, 5'd0, 5'd31, 6'd63, 6'd63}, 16'd1, 8'd3});
    pending_records.push_back('{32'd12_345678, 32'd45_600000,
                                {6'd63, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59}, 16'd2, 8'd128});
    pending_records.push_back('{32'd1, 32'd99, {6'd4, 4'd13, 5'd1, 5'd0, 6'd0, 6'd0}, 16'd3, 8'd127});
    pending_records.push_back('{32'h5555_5555, 32'hAAAA_AAAA,
                                {6'd20, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0}, 16'hAAAA, 8'h55});
    drain();

    // backup on, skip-old off, start time at top
    write_reg(REG_BACKUP_EN, 32'd1);
    write_reg(REG_SKIP_OLD, 32'd0);
    write_reg(REG_START_TIME, 32'hFFFF_FFFF);
    pending_records.push_back('{32'd1_000000, 32'd2_000000, 32'hFFFF_FFFF, 16'd7, 8'd9});
    pending_records.push_back('{32'd1_000000, 32'd2_000000, 32'h0000_0001, 16'd7, 8'd9});
    drain();
    write_reg(REG_START_TIME, 32'h0);
    pending_records.push_back('{32'd1_000000, 32'd2_000000, 32'h0, 16'd7, 8'd9});
    pending_records.push_back('{32'd1_000000, 32'd2_000000, 32'h1, 16'd7, 8'd9});
    pending_records.push_back('{32'd1_000000, 32'd2_000000, 32'h1, 16'd7, 8'd9});
    drain();

    // random phases across settings
    add_random(130, 32'h5000_0000);
    drain();
    write_reg(REG_SKIP_OLD, 32'd1);
    write_reg(REG_START_TIME, 32'h4000_0000);
    add_random(140, 32'h4000_0000);
    drain();
    write_reg(REG_BACKUP_EN, 32'd0);
    add_random(130, $urandom);
    drain();
    write_reg(REG_BACKUP_EN, 32'd1);
    write_reg(REG_START_TIME, $urandom);
    quiet = 1'b1;
    add_random(130, 32'h6000_0000);
    drain();

    if (mismatches == 0 && expected_fixes.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #50ms;
    $display("Test completed with failures");
    $finish;
  end
endmodule
